// ----- sv/ppm_frame_decoder_defines.svh -----
// Assertion macros shared by the PPM frame decoder modules.
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define PPMFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A consequence that must hold in the cycle after its trigger.
`define PPMFD_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
// A consequence that must hold in the same cycle as its trigger.
`define PPMFD_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);
`else
`define PPMFD_ASSERT_ALWAYS(lbl, cond, msg)
`define PPMFD_ASSERT_NEXT(lbl, trig, cons, msg)
`define PPMFD_ASSERT_SAME(lbl, trig, cons, msg)
`endif

`endif

// ----- sv/ppmfd_pkg.sv -----
// Shared constants and types of the PPM frame decoder.
package ppmfd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int TICK_W   = 16;
    localparam int STAMP_W  = 64;
    localparam int MINCH_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PULSE_MAX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_WIDTH_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_WIDTH_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GAP_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_CHANNELS = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0]  RST_LOW_PULSE_MAX      = 16'd500;
    localparam logic [TICK_W-1:0]  RST_CHANNEL_WIDTH_MIN  = 16'd800;
    localparam logic [TICK_W-1:0]  RST_CHANNEL_WIDTH_MAX  = 16'd2200;
    localparam logic [TICK_W-1:0]  RST_START_GAP_MIN      = 16'd2500;
    localparam logic [MINCH_W-1:0] RST_MIN_FRAME_CHANNELS = 4'd5;

    // Decoder phase codes.
    localparam logic [1:0] PH_SYNC     = 2'd0;
    localparam logic [1:0] PH_ARMING   = 2'd1;
    localparam logic [1:0] PH_ACTIVE   = 2'd2;
    localparam logic [1:0] PH_INACTIVE = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0]  low_pulse_max;
        logic [TICK_W-1:0]  channel_width_min;
        logic [TICK_W-1:0]  channel_width_max;
        logic [TICK_W-1:0]  start_gap_min;
        logic [MINCH_W-1:0] min_frame_channels;
    } cfg_t;

endpackage

// ----- sv/ppmfd_store.sv -----
// Frame store: synchronous channel-width memory with registered read data.
module ppmfd_store #(
    parameter int DEPTH = ppmfd_pkg::MAX_CHANNELS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [ppmfd_pkg::TICK_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [ppmfd_pkg::TICK_W-1:0]  rd_data
);

    logic [ppmfd_pkg::TICK_W-1:0] store_mem [DEPTH];
    logic [ppmfd_pkg::TICK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ppmfd_core.sv -----
// Edge decoder and frame publishing sequencer around the frame store.
`include "ppm_frame_decoder_defines.svh"

module ppmfd_core #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppmfd_pkg::cfg_t                   cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppmfd_pkg::TICK_W-1:0]      capture_time,
    input  logic                              capture_overflow,
    input  logic [ppmfd_pkg::STAMP_W-1:0]     now_ticks,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              frame_valid,
    output logic [ppmfd_pkg::INDEX_W-1:0]     channel_index,
    output logic [ppmfd_pkg::TICK_W-1:0]      pulse_width,
    output logic [ppmfd_pkg::STAMP_W-1:0]     frame_time,
    output logic                              last_of_frame
);

    localparam int CW   = $clog2(MAX_CHANNELS + 1);
    localparam int IW   = $clog2(MAX_CHANNELS);
    localparam int CMPW = (CW > ppmfd_pkg::MINCH_W) ? CW : ppmfd_pkg::MINCH_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PUB_RD = 2'd1;
    localparam logic [1:0] ST_PUB_WT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [1:0]                      phase_reg, phase_next;
    logic [ppmfd_pkg::TICK_W-1:0]    edge_reg, edge_next;
    logic [ppmfd_pkg::TICK_W-1:0]    mark_reg, mark_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   pub_count_reg, pub_count_next;
    logic [CW-1:0]                   pub_idx_reg, pub_idx_next;
    logic                            pub_valid_reg, pub_valid_next;
    logic [ppmfd_pkg::STAMP_W-1:0]   pub_time_reg, pub_time_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_fv_reg, out_fv_next;
    logic [ppmfd_pkg::INDEX_W-1:0]   out_idx_reg, out_idx_next;
    logic [ppmfd_pkg::TICK_W-1:0]    out_width_reg, out_width_next;
    logic [ppmfd_pkg::STAMP_W-1:0]   out_time_reg, out_time_next;
    logic                            out_last_reg, out_last_next;

    logic                            in_acc;
    logic                            out_free;
    logic                            out_load;
    logic [ppmfd_pkg::TICK_W-1:0]    gap;
    logic [ppmfd_pkg::TICK_W-1:0]    width;
    logic [ppmfd_pkg::MINCH_W-1:0]   need;
    logic                            frame_ok;
    logic                            pub_last;
    logic                            store_we;
    logic                            store_re;
    logic [ppmfd_pkg::TICK_W-1:0]    store_rdata;

    ppmfd_store #(
        .DEPTH (MAX_CHANNELS),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (width),
        .rd_en   (store_re),
        .rd_addr (pub_idx_reg[IW-1:0]),
        .rd_data (store_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_PUB_WT) && out_free;

    assign gap   = capture_time - edge_reg;
    assign width = capture_time - mark_reg;
    assign need  = (cfg.min_frame_channels == '0) ? ppmfd_pkg::MINCH_W'(1)
                                                  : cfg.min_frame_channels;
    assign frame_ok = (count_reg != '0) && (CMPW'(count_reg) >= CMPW'(need));
    assign pub_last = !pub_valid_reg || ((pub_idx_reg + CW'(1)) == pub_count_reg);
    assign store_re = (state_reg == ST_PUB_RD) && pub_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        edge_next      = edge_reg;
        mark_next      = mark_reg;
        count_next     = count_reg;
        pub_count_next = pub_count_reg;
        pub_idx_next   = pub_idx_reg;
        pub_valid_next = pub_valid_reg;
        pub_time_next  = pub_time_reg;
        store_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (capture_overflow)
                    begin
                        phase_next = ppmfd_pkg::PH_SYNC;
                        count_next = '0;
                    end
                    else
                    begin
                        edge_next = capture_time;
                        if (gap >= cfg.start_gap_min)
                        begin
                            pub_valid_next = frame_ok;
                            pub_count_next = count_reg;
                            pub_idx_next   = '0;
                            pub_time_next  = now_ticks;
                            count_next     = '0;
                            phase_next     = ppmfd_pkg::PH_ARMING;
                            state_next     = ST_PUB_RD;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                ppmfd_pkg::PH_SYNC:
                                begin
                                end
                                ppmfd_pkg::PH_ARMING:
                                begin
                                    if (gap > cfg.low_pulse_max)
                                    begin
                                        phase_next = ppmfd_pkg::PH_SYNC;
                                        count_next = '0;
                                    end
                                    else
                                    begin
                                        mark_next  = capture_time;
                                        phase_next = ppmfd_pkg::PH_INACTIVE;
                                    end
                                end
                                ppmfd_pkg::PH_INACTIVE:
                                begin
                                    phase_next = ppmfd_pkg::PH_ACTIVE;
                                end
                                ppmfd_pkg::PH_ACTIVE:
                                begin
                                    mark_next = capture_time;
                                    if ((width < cfg.channel_width_min) ||
                                        (width > cfg.channel_width_max))
                                    begin
                                        phase_next = ppmfd_pkg::PH_SYNC;
                                        count_next = '0;
                                    end
                                    else
                                    begin
                                        if (count_reg < CW'(MAX_CHANNELS))
                                        begin
                                            store_we   = 1'b1;
                                            count_next = count_reg + CW'(1);
                                        end
                                        phase_next = ppmfd_pkg::PH_INACTIVE;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            ST_PUB_RD:
            begin
                state_next = ST_PUB_WT;
            end
            ST_PUB_WT:
            begin
                if (out_free)
                begin
                    if (pub_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pub_idx_next = pub_idx_reg + CW'(1);
                        state_next   = ST_PUB_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_fv_next    = out_fv_reg;
        out_idx_next   = out_idx_reg;
        out_width_next = out_width_reg;
        out_time_next  = out_time_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_fv_next    = pub_valid_reg;
            out_idx_next   = pub_idx_reg[ppmfd_pkg::INDEX_W-1:0];
            out_width_next = pub_valid_reg ? store_rdata : '0;
            out_time_next  = pub_time_reg;
            out_last_next  = pub_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= ppmfd_pkg::PH_SYNC;
            edge_reg      <= '0;
            mark_reg      <= '0;
            count_reg     <= '0;
            pub_count_reg <= '0;
            pub_idx_reg   <= '0;
            pub_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            edge_reg      <= edge_next;
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            pub_count_reg <= pub_count_next;
            pub_idx_reg   <= pub_idx_next;
            pub_valid_reg <= pub_valid_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pub_time_reg  <= pub_time_next;
        out_fv_reg    <= out_fv_next;
        out_idx_reg   <= out_idx_next;
        out_width_reg <= out_width_next;
        out_time_reg  <= out_time_next;
    end

    assign out_valid     = out_valid_reg;
    assign frame_valid   = out_fv_reg;
    assign channel_index = out_idx_reg;
    assign pulse_width   = out_width_reg;
    assign frame_time    = out_time_reg;
    assign last_of_frame = out_last_reg;

    // The store is only written while idle, so a publish run never races a write.
    `PPMFD_ASSERT_SAME(a_no_write_in_publish, state_reg != ST_IDLE, !store_we, "store written during publish")
    `PPMFD_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_CHANNELS), "channel count above maximum")
    `PPMFD_ASSERT_NEXT(a_overflow_resync, in_acc && capture_overflow, (phase_reg == ppmfd_pkg::PH_SYNC) && (count_reg == '0), "overflow did not resync")
    `PPMFD_ASSERT_NEXT(a_reject_is_last, out_load && !pub_valid_reg, out_last_reg && (out_width_reg == '0), "rejected frame result malformed")

endmodule

// ----- sv/ppm_frame_decoder.sv -----
// Top level of the PPM frame decoder: ports, configuration registers, core.
//
//   Channel   Direction  Handshake                      Carries
//   s_axis    in         s_axis_tvalid / s_axis_tready  one captured edge
//   m_axis    out        m_axis_tvalid / m_axis_tready  one channel of a frame or a reject
//   cfg       in         cfg_wr_en (no wait)            one register write
//
// An edge transaction that does not close a frame keeps the decoder idle, and the
// next edge can be accepted in the following cycle. An edge that closes a frame of
// N valid channels starts a publish run with one frame store read and one output
// register load per result; a rejected frame yields one result and no store read.
// Stalls on m_axis stretch a publish run; s_axis_tready stays low until the last
// result of the run sits in the output register. Reset is asynchronous and takes
// effect at once; the frame store needs no clearing pass.
`include "ppm_frame_decoder_defines.svh"

module ppm_frame_decoder #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: capture_time[15:0], now_ticks[79:16]
    input  logic [ppmfd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: capture_overflow[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: channel_index[2:0], pulse_width[18:3], frame_time[82:19], zero[87:83]
    output logic [ppmfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: frame_valid[0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [ppmfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PAD_W = ppmfd_pkg::OUT_DATA_W - ppmfd_pkg::INDEX_W
                         - ppmfd_pkg::TICK_W - ppmfd_pkg::STAMP_W;

    ppmfd_pkg::cfg_t                  cfg_reg, cfg_next;
    logic [ppmfd_pkg::INDEX_W-1:0]    channel_index;
    logic [ppmfd_pkg::TICK_W-1:0]     pulse_width;
    logic [ppmfd_pkg::STAMP_W-1:0]    frame_time;

    // Configuration writes land in the addressed register; other indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ppmfd_pkg::CFG_LOW_PULSE_MAX:      cfg_next.low_pulse_max = cfg_data;
                ppmfd_pkg::CFG_CHANNEL_WIDTH_MIN:  cfg_next.channel_width_min = cfg_data;
                ppmfd_pkg::CFG_CHANNEL_WIDTH_MAX:  cfg_next.channel_width_max = cfg_data;
                ppmfd_pkg::CFG_START_GAP_MIN:      cfg_next.start_gap_min = cfg_data;
                ppmfd_pkg::CFG_MIN_FRAME_CHANNELS:
                    cfg_next.min_frame_channels = cfg_data[ppmfd_pkg::MINCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_pulse_max      <= ppmfd_pkg::RST_LOW_PULSE_MAX;
            cfg_reg.channel_width_min  <= ppmfd_pkg::RST_CHANNEL_WIDTH_MIN;
            cfg_reg.channel_width_max  <= ppmfd_pkg::RST_CHANNEL_WIDTH_MAX;
            cfg_reg.start_gap_min      <= ppmfd_pkg::RST_START_GAP_MIN;
            cfg_reg.min_frame_channels <= ppmfd_pkg::RST_MIN_FRAME_CHANNELS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The core decodes each edge transaction and runs the publish sequence,
    // reading the frame store one channel at a time into its output register.
    ppmfd_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .capture_time     (s_axis_tdata[15:0]),
        .capture_overflow (s_axis_tuser),
        .now_ticks        (s_axis_tdata[79:16]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .frame_valid      (m_axis_tuser),
        .channel_index    (channel_index),
        .pulse_width      (pulse_width),
        .frame_time       (frame_time),
        .last_of_frame    (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, frame_time, pulse_width, channel_index};

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the PPM frame decoder with its own decoding predictor.
module testbench;

    // The decoder is built with its default channel capacity.
    localparam int MAX_CH = ppmfd_pkg::MAX_CHANNELS_DEF;
    // Scaled with the channel capacity to cover any publish run still in flight.
    localparam int SETTLE_CYCLES = 2 * MAX_CH + 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int ROUND_ITEMS = 6;

    // Reset values of the registers as plain integers.
    localparam int LPM_RST   = int'(ppmfd_pkg::RST_LOW_PULSE_MAX);
    localparam int WMIN_RST  = int'(ppmfd_pkg::RST_CHANNEL_WIDTH_MIN);
    localparam int WMAX_RST  = int'(ppmfd_pkg::RST_CHANNEL_WIDTH_MAX);
    localparam int SG_RST    = int'(ppmfd_pkg::RST_START_GAP_MIN);
    localparam int MINCH_RST = int'(ppmfd_pkg::RST_MIN_FRAME_CHANNELS);

    // Ways in which a generated frame can be spoiled on purpose.
    typedef enum int
    {
        FLAW_NONE,
        FLAW_LONG_PULSE,
        FLAW_BAD_WIDTH,
        FLAW_OVERFLOW
    } frame_flaw_t;

    // One expected channel transaction on the output stream.
    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [15:0] width;
        logic [63:0] stamp;
        logic        last;
    } chan_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // tdata: capture_time[15:0], now_ticks[79:16]
    logic [ppmfd_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    // tuser: capture_overflow[0]
    logic                                s_axis_tuser = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // tdata: channel_index[2:0], pulse_width[18:3], frame_time[82:19], zero[87:83]
    logic [ppmfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    // tuser: frame_valid[0]
    logic                                m_axis_tuser;
    logic                                m_axis_tlast;
    logic                                cfg_wr_en = 1'b0;
    logic [ppmfd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [ppmfd_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    // Predictor state: a private copy of the decoder's registers and pulse-train state.
    ppmfd_pkg::cfg_t         decoder_cfg;
    logic [15:0]             last_edge_tick;
    logic [15:0]             last_mark_tick;
    logic [15:0]             width_store [MAX_CH];
    logic [3:0]              stored_chans;
    logic [1:0]              decoder_phase;
    chan_result_t            chan_expect_q[$];

    // Stimulus bookkeeping.
    logic [15:0]             cap_clock = '0;
    int                      edges_accepted = 0;
    int                      error_count = 0;
    logic                    tx_back_to_back = 1'b0;
    logic                    long_hold_req = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ppm_frame_decoder #(
        .MAX_CHANNELS (MAX_CH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic logic [63:0] random_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic ppmfd_pkg::cfg_t make_setting(input int lpm, input int wmin,
                                                     input int wmax, input int sg,
                                                     input int minch);
        ppmfd_pkg::cfg_t s;
        s.low_pulse_max      = lpm[15:0];
        s.channel_width_min  = wmin[15:0];
        s.channel_width_max  = wmax[15:0];
        s.start_gap_min      = sg[15:0];
        s.min_frame_channels = minch[3:0];
        return s;
    endfunction

    // Any broken pulse train throws away the partial frame and waits for a start gap.
    task automatic lose_sync();
        decoder_phase = ppmfd_pkg::PH_SYNC;
        stored_chans  = '0;
    endtask

    // Predicts what one accepted capture transaction does to the decoder, and queues
    // every channel transaction that it causes.
    task automatic decode_edge(input logic [15:0] cap, input logic ovf,
                               input logic [63:0] stamp);
        logic [15:0]  gap;
        logic [15:0]  mark_width;
        int           need;
        int           ch;
        chan_result_t res;
        gap = cap - last_edge_tick;
        if (ovf)
        begin
            // A lost capture leaves the last kept edge time untouched.
            lose_sync();
        end
        else
        begin
            last_edge_tick = cap;
            if (gap >= decoder_cfg.start_gap_min)
            begin
                // The start gap wins over any phase: publish, then arm for the next frame.
                need = (decoder_cfg.min_frame_channels == 0) ?
                       1 : int'(decoder_cfg.min_frame_channels);
                if (stored_chans >= need && stored_chans > 0 && stored_chans <= MAX_CH)
                begin
                    for (ch = 0; ch < stored_chans; ch++)
                    begin
                        res.valid = 1'b1;
                        res.index = ch[2:0];
                        res.width = width_store[ch];
                        res.stamp = stamp;
                        res.last  = (ch + 1 == stored_chans);
                        chan_expect_q.push_back(res);
                    end
                end
                else
                begin
                    // Too short a frame yields a single reject transaction.
                    res.valid = 1'b0;
                    res.index = '0;
                    res.width = '0;
                    res.stamp = stamp;
                    res.last  = 1'b1;
                    chan_expect_q.push_back(res);
                end
                stored_chans  = '0;
                decoder_phase = ppmfd_pkg::PH_ARMING;
            end
            else
            begin
                unique case (decoder_phase)
                    ppmfd_pkg::PH_ARMING:
                    begin
                        if (gap > decoder_cfg.low_pulse_max)
                        begin
                            lose_sync();
                        end
                        else
                        begin
                            last_mark_tick = cap;
                            decoder_phase  = ppmfd_pkg::PH_INACTIVE;
                        end
                    end
                    ppmfd_pkg::PH_INACTIVE:
                    begin
                        decoder_phase = ppmfd_pkg::PH_ACTIVE;
                    end
                    ppmfd_pkg::PH_ACTIVE:
                    begin
                        mark_width     = cap - last_mark_tick;
                        last_mark_tick = cap;
                        if (mark_width < decoder_cfg.channel_width_min ||
                            mark_width > decoder_cfg.channel_width_max)
                        begin
                            lose_sync();
                        end
                        else
                        begin
                            // Channels past the store capacity are measured but dropped.
                            if (stored_chans < MAX_CH)
                            begin
                                width_store[stored_chans[2:0]] = mark_width;
                                stored_chans++;
                            end
                            decoder_phase = ppmfd_pkg::PH_INACTIVE;
                        end
                    end
                    default:
                    begin
                        // Out of sync: only a start gap brings the decoder back.
                    end
                endcase
            end
        end
    endtask

    // Offers one capture transaction, taken a given number of ticks after the previous
    // capture, and runs the predictor once it has been accepted. The valid line is only
    // lowered for an idle pause before the offer, so back-to-back transactions keep it high.
    task automatic send_capture(input int gap, input logic ovf, input logic [63:0] stamp);
        int pause;
        int roll;
        cap_clock = cap_clock + gap[15:0];
        roll = $urandom_range(0, 99);
        if (tx_back_to_back || roll < 45)
            pause = 0;
        else if (roll < 85)
            pause = $urandom_range(1, 3);
        else if (roll < 97)
            pause = $urandom_range(4, 12);
        else
            pause = $urandom_range(25, 60);
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_axis_tdata  <= {stamp, cap_clock};
        s_axis_tuser  <= ovf;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        decode_edge(cap_clock, ovf, stamp);
        edges_accepted++;
    endtask

    // A gap at or above the start threshold closes whatever frame is open.
    task automatic close_frame();
        send_capture($urandom_range(decoder_cfg.start_gap_min, 65535), 1'b0, random_stamp());
    endtask

    // Random captures at random distances, some of them flagged as overrun.
    task automatic send_noise(input int count);
        repeat (count)
            send_capture($urandom_range(0, 65535), $urandom_range(0, 7) == 0, random_stamp());
    endtask

    // Sends a start gap, the first low pulse and the given number of channels. Every gap
    // inside the frame stays below the start threshold, and every channel width falls in
    // the current window where the window allows it, unless the frame is spoiled on purpose.
    task automatic send_frame(input int chans, input frame_flaw_t flaw);
        int lpm;
        int wmin;
        int wmax;
        int lim;
        int wcap;
        int whi;
        int w;
        int g;
        int bad_ch;
        int ch;
        lpm  = int'(decoder_cfg.low_pulse_max);
        wmin = int'(decoder_cfg.channel_width_min);
        wmax = int'(decoder_cfg.channel_width_max);
        lim  = int'(decoder_cfg.start_gap_min) - 1;
        wcap = (2 * lim > 65535) ? 65535 : 2 * lim;
        whi  = (wmax < wcap) ? wmax : wcap;
        bad_ch = (chans > 0) ? $urandom_range(0, chans - 1) : 0;
        close_frame();
        if (lim >= 0)
        begin
            g = (lpm < lim) ? lpm : lim;
            if (flaw == FLAW_LONG_PULSE && g < lim)
                g = $urandom_range(g + 1, lim);
            else
                g = $urandom_range(0, g);
            send_capture(g, 1'b0, random_stamp());
            for (ch = 0; ch < chans; ch++)
            begin
                if (wmin <= whi)
                    w = $urandom_range(wmin, whi);
                else
                    w = $urandom_range(0, wcap);
                if (flaw == FLAW_BAD_WIDTH && ch == bad_ch)
                begin
                    if (wmin > 0 && ($urandom_range(0, 1) == 0 || wmax >= wcap))
                        w = $urandom_range(0, wmin - 1);
                    else if (wmax < wcap)
                        w = $urandom_range(wmax + 1, wcap);
                end
                // Split the mark-to-mark width into two gaps that both stay inside the frame.
                g = (w > lim) ? $urandom_range(w - lim, lim) : $urandom_range(0, w);
                send_capture(g, 1'b0, random_stamp());
                send_capture(w - g, flaw == FLAW_OVERFLOW && ch == bad_ch, random_stamp());
            end
        end
    endtask

    // Stops offering and waits until every predicted channel transaction has come out,
    // then lets the decoder finish anything that produces no output.
    task automatic wait_drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (chan_expect_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (chan_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected channel transactions never arrived",
                     $time, chan_expect_q.size());
            error_count++;
            chan_expect_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [ppmfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppmfd_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Registers are only written while the decoder is idle; all five are written each time.
    task automatic program_decoder(input ppmfd_pkg::cfg_t setting);
        wait_drain();
        put_reg(ppmfd_pkg::CFG_LOW_PULSE_MAX, setting.low_pulse_max);
        put_reg(ppmfd_pkg::CFG_CHANNEL_WIDTH_MIN, setting.channel_width_min);
        put_reg(ppmfd_pkg::CFG_CHANNEL_WIDTH_MAX, setting.channel_width_max);
        put_reg(ppmfd_pkg::CFG_START_GAP_MIN, setting.start_gap_min);
        put_reg(ppmfd_pkg::CFG_MIN_FRAME_CHANNELS,
                {{(ppmfd_pkg::CFG_DATA_W - ppmfd_pkg::MINCH_W){1'b0}},
                 setting.min_frame_channels});
        cfg_wr_en <= 1'b0;
        decoder_cfg = setting;
    endtask

    // Hand-picked pulse trains under the reset settings.
    task automatic test_directed_defaults();
        int widths [5];
        int ch;
        widths = '{800, 2200, 1000, 1200, 1500};
        // A gap exactly at the start threshold closes an empty frame: one reject.
        send_capture(SG_RST, 1'b0, 64'd0);
        // First low pulse at its longest allowed length.
        send_capture(LPM_RST, 1'b0, random_stamp());
        // Five channels, the window edges among them.
        for (ch = 0; ch < 5; ch++)
        begin
            send_capture(300, 1'b0, random_stamp());
            send_capture(widths[ch] - 300, 1'b0, random_stamp());
        end
        // The widest gap publishes the frame, stamped with all ones.
        send_capture(65535, 1'b0, '1);
        // One tick too long for the first low pulse.
        send_capture(LPM_RST + 1, 1'b0, random_stamp());
        // A lost capture yields nothing and does not move the last kept edge time...
        send_capture(3000, 1'b1, random_stamp());
        // ...so a zero gap after it still counts as a start gap.
        send_capture(0, 1'b0, random_stamp());
        // Shortest low pulse, then a width one tick below the window.
        send_capture(0, 1'b0, random_stamp());
        send_capture(400, 1'b0, random_stamp());
        send_capture(399, 1'b0, random_stamp());
        send_capture(SG_RST, 1'b0, random_stamp());
        // A single good channel is still too few at the reset minimum.
        send_capture(100, 1'b0, random_stamp());
        send_capture(100, 1'b0, random_stamp());
        send_capture(700, 1'b0, random_stamp());
        send_capture(SG_RST, 1'b0, random_stamp());
    endtask

    // Register values at and beyond their limits.
    task automatic test_extreme_settings();
        // Widest window, start only on a full-scale gap, zero minimum treated as one.
        program_decoder(make_setting(0, 0, 65535, 65535, 0));
        send_frame(1, FLAW_NONE);
        send_frame(0, FLAW_NONE);
        close_frame();
        // One exact width, generous low pulse, a full frame with extra channels.
        program_decoder(make_setting(65535, 1000, 1000, 1001, MAX_CH));
        send_frame(MAX_CH + 2, FLAW_NONE);
        close_frame();
        // An empty window rejects every width.
        program_decoder(make_setting(LPM_RST, 3000, 2000, 4000, 1));
        send_frame(2, FLAW_NONE);
        close_frame();
        // A zero start threshold makes every kept capture close a frame.
        program_decoder(make_setting(LPM_RST, WMIN_RST, WMAX_RST, 0, MINCH_RST));
        send_noise(4);
        // A minimum above the capacity never lets a frame through.
        program_decoder(make_setting(LPM_RST, WMIN_RST, WMAX_RST, SG_RST, 15));
        send_frame(MAX_CH, FLAW_NONE);
        close_frame();
        program_decoder(make_setting(LPM_RST, WMIN_RST, WMAX_RST, SG_RST, 1));
        send_frame(1, FLAW_NONE);
        send_frame(2, FLAW_BAD_WIDTH);
        close_frame();
    endtask

    // Mostly clean frames with random content, some spoiled ones and some noise,
    // under the reset settings first and then random ones.
    task automatic test_random_rounds();
        int              round;
        int              roll;
        int              chans;
        int              wmin;
        int              stop_at;
        ppmfd_pkg::cfg_t setting;
        for (round = 0; round < 2; round++)
        begin
            if (round == 0)
            begin
                setting = make_setting(LPM_RST, WMIN_RST, WMAX_RST, SG_RST, MINCH_RST);
            end
            else
            begin
                wmin = $urandom_range(0, 1200);
                setting = make_setting($urandom_range(0, 800), wmin,
                                       wmin + $urandom_range(0, 1500),
                                       $urandom_range(1200, 6000),
                                       ($urandom_range(0, 9) == 0) ?
                                       $urandom_range(9, 15) : $urandom_range(0, 8));
            end
            program_decoder(setting);
            stop_at = edges_accepted + ROUND_ITEMS;
            while (edges_accepted < stop_at)
            begin
                roll  = $urandom_range(0, 99);
                chans = ($urandom_range(0, 9) < 7) ?
                        $urandom_range(3, MAX_CH) : $urandom_range(0, MAX_CH + 2);
                if (roll < 70)
                    send_frame(chans, FLAW_NONE);
                else if (roll < 85)
                    send_frame($urandom_range(1, MAX_CH),
                               frame_flaw_t'($urandom_range(1, 3)));
                else
                    send_noise($urandom_range(1, 4));
            end
            close_frame();
        end
    endtask

    // The receiver holds off for a long stretch while frames arrive back to back,
    // so the output fills and the decoder must stall its input. Afterwards the sender
    // stays quiet until the whole burst has been delivered.
    task automatic test_output_backpressure();
        program_decoder(make_setting(LPM_RST, WMIN_RST, WMAX_RST, SG_RST, MINCH_RST));
        tx_back_to_back = 1'b1;
        long_hold_req   = 1'b1;
        send_frame(MAX_CH, FLAW_NONE);
        send_frame(3, FLAW_NONE);
        close_frame();
        tx_back_to_back = 1'b0;
        wait_drain();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Output side: random ready with short and long holds, quiet stretches with no
    // holds at all, and one long hold-off when a test asks for it.
    initial
    begin : channel_sink
        int hold_left;
        int free_left;
        int roll;
        hold_left = 0;
        free_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
                free_left     = 0;
            end
            if (hold_left == 0 && free_left == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    free_left = $urandom_range(20, 60);
                else if (roll < 11)
                    hold_left = $urandom_range(15, 40);
                else if (roll < 40)
                    hold_left = $urandom_range(1, 3);
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (free_left > 0)
                    free_left--;
            end
        end
    end

    // Every output transaction is compared field by field with the oldest prediction.
    always @(posedge clk)
    begin : check_channels
        chan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (chan_expect_q.size() == 0)
            begin
                $display("%0t: unexpected channel transaction, expected none, got %h/%b/%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = chan_expect_q.pop_front();
                check_field("frame_valid", 64'(want.valid), 64'(m_axis_tuser));
                check_field("channel_index", 64'(want.index), 64'(m_axis_tdata[2:0]));
                check_field("pulse_width", 64'(want.width), 64'(m_axis_tdata[18:3]));
                check_field("frame_time", want.stamp, m_axis_tdata[82:19]);
                check_field("last_of_frame", 64'(want.last), 64'(m_axis_tlast));
                check_field("tdata padding", 64'd0, 64'(m_axis_tdata[87:83]));
            end
        end
    end

    // Main sequence: reset once, run each test in turn, then wait for the tail.
    initial
    begin
        decoder_cfg    = make_setting(LPM_RST, WMIN_RST, WMAX_RST, SG_RST, MINCH_RST);
        last_edge_tick = '0;
        last_mark_tick = '0;
        stored_chans   = '0;
        decoder_phase  = ppmfd_pkg::PH_SYNC;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_extreme_settings();
        test_random_rounds();
        test_output_backpressure();
        wait_drain();
        if (error_count == 0)
            $display("ppm_frame_decoder: match");
        else
            $display("ppm_frame_decoder: mismatch");
        $finish;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    initial
    begin
        #2_000_000;
        $display("ppm_frame_decoder: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ppmfd_pkg.sv
sv/ppmfd_store.sv
sv/ppmfd_core.sv
sv/ppm_frame_decoder.sv
test/testbench.sv
